// ----- rtl/rpn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int MAX_RESULTS = 64;
    localparam int RC_W = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] K_PEEK = 3'd0;
    localparam logic [2:0] K_PEEK_ALL = 3'd1;
    localparam logic [2:0] K_POP = 3'd2;
    localparam logic [2:0] K_POP_ALL = 3'd3;
    localparam logic [2:0] K_UNDER = 3'd4;
    localparam logic [2:0] K_OVER = 3'd5;

    // command characters
    localparam logic [7:0] CH_HEX_OFF = 8'h68;
    localparam logic [7:0] CH_HEX_ON = 8'h48;
    localparam logic [7:0] CH_PEEK = 8'h70;
    localparam logic [7:0] CH_PEEK_ALL = 8'h50;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_POP = 8'h76;
    localparam logic [7:0] CH_POP_ALL = 8'h56;
    localparam logic [7:0] CH_DUP = 8'h75;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_REM = 8'h25;
    localparam logic [7:0] CH_AND = 8'h26;
    localparam logic [7:0] CH_OR = 8'h7C;
    localparam logic [7:0] CH_XOR = 8'h5E;
    localparam logic [7:0] CH_NOT = 8'h7E;
    localparam logic [7:0] CH_QUIT = 8'h71;

    typedef enum logic [1:0] {
        PS_START, PS_OPERATOR, PS_NUMBER, PS_FINAL
    } parse_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_PUSH, ST_OP, ST_RD, ST_RD2, ST_EMIT,
        ST_LOOP_RD, ST_LOOP_EMIT, ST_DIV, ST_WB, ST_MUL
    } state_t;

    typedef enum logic [2:0] {
        LOOP_NONE, LOOP_PEEK, LOOP_POPALL
    } loop_t;
endpackage
`default_nettype wire

// ----- rtl/rpn_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rpn_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic        want_rem,
    output logic             done,
    output logic      [31:0] result
);
    import rpn_pkg::*;

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic na_reg, na_next, nb_reg, nb_next, rem_reg, rem_next, z_reg, z_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        na_reg <= na_next;
        nb_reg <= nb_next;
        rem_reg <= rem_next;
        z_reg <= z_next;
    end

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        na_next = na_reg;
        nb_next = nb_reg;
        rem_next = rem_reg;
        z_next = z_reg;
        shifted = {r_reg, q_reg[31]};
        trial = shifted - {1'b0, d_reg};
        if (start)
        begin
            na_next = a[31];
            nb_next = b[31];
            q_next = a[31] ? (32'd0 - a) : a;
            d_next = b[31] ? (32'd0 - b) : b;
            r_next = '0;
            rem_next = want_rem;
            z_next = (b == 32'd0);
            n_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg != 6'd0)
            begin
                if (!trial[32])
                begin
                    r_next = trial[31:0];
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = shifted[31:0];
                    q_next = {q_reg[30:0], 1'b0};
                end
                n_next = n_reg - 6'd1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign done = busy_reg && (n_reg == 6'd0);
    always_comb
    begin
        if (z_reg)
            result = '0;
        else if (rem_reg)
            result = na_reg ? (32'd0 - r_reg) : r_reg;
        else
            result = (na_reg ^ nb_reg) ? (32'd0 - q_reg) : q_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/rpn_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rpn_datapath (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    acc_clear,
    input  wire logic                    acc_digit,
    input  wire logic [3:0]              digit,
    input  wire logic                    hex,
    input  wire logic                    mem_we,
    input  wire logic [rpn_pkg::SP_W-1:0] mem_waddr,
    input  wire logic                    wsel_acc,
    input  wire logic                    wsel_top,
    input  wire logic                    wsel_alu,
    input  wire logic                    mem_re,
    input  wire logic [rpn_pkg::SP_W-1:0] mem_raddr,
    input  wire logic                    cap_a,
    input  wire logic                    cap_b,
    input  wire logic [7:0]              op,
    input  wire logic                    alu_go,
    input  wire logic                    div_start,
    output logic                         div_done,
    output logic [31:0]                  rdata,
    output logic [31:0]                  a_val
);
    import rpn_pkg::*;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] acc_reg;
    logic [31:0] a_reg, b_reg, alu_reg, rd_reg;
    logic [31:0] wdata, alu_next, div_res;

    rpn_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(a_reg), .b(b_reg),
        .want_rem(op == CH_REM), .done(div_done), .result(div_res)
    );

    always_ff @(posedge clk)
    begin
        if (acc_clear)
            acc_reg <= '0;
        else if (acc_digit)
            acc_reg <= (hex ? {acc_reg[27:0], 4'd0}
                            : ({acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0}))
                       + {28'd0, digit};
        if (mem_we)
            mem[mem_waddr] <= wdata;
        if (mem_re)
            rd_reg <= mem[mem_raddr];
        if (cap_a)
            a_reg <= rd_reg;
        if (cap_b)
            b_reg <= rd_reg;
        if (alu_go)
            alu_reg <= alu_next;
        else if (div_done)
            alu_reg <= div_res;
    end

    always_comb
    begin
        unique case (op)
            CH_ADD: alu_next = a_reg + b_reg;
            CH_SUB: alu_next = a_reg - b_reg;
            CH_MUL: alu_next = a_reg * b_reg;
            CH_AND: alu_next = a_reg & b_reg;
            CH_OR: alu_next = a_reg | b_reg;
            CH_XOR: alu_next = a_reg ^ b_reg;
            default: alu_next = ~a_reg;
        endcase
    end

    always_comb
    begin
        if (wsel_acc)
            wdata = acc_reg;
        else if (wsel_top)
            wdata = a_reg;
        else if (wsel_alu)
            wdata = alu_reg;
        else
            wdata = rd_reg;
    end

    assign rdata = rd_reg;
    assign a_val = a_reg;
endmodule
`default_nettype wire

// ----- rtl/rpn_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rpn_control (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               char_code,
    input  wire logic                     end_of_input,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [2:0]                    kind,
    output logic [31:0]                   value,
    output logic                          hex_radix,
    output logic                          last,
    output logic                          acc_clear,
    output logic                          acc_digit,
    output logic [3:0]                    digit,
    output logic                          hex,
    output logic                          mem_we,
    output logic [rpn_pkg::SP_W-1:0]      mem_waddr,
    output logic                          wsel_acc,
    output logic                          wsel_top,
    output logic                          wsel_alu,
    output logic                          mem_re,
    output logic [rpn_pkg::SP_W-1:0]      mem_raddr,
    output logic                          cap_a,
    output logic                          cap_b,
    output logic [7:0]                    op,
    output logic                          alu_go,
    output logic                          div_start,
    input  wire logic                     div_done,
    input  wire logic [31:0]              rdata,
    input  wire logic [31:0]              a_val
);
    import rpn_pkg::*;

    state_t state_reg, state_next;
    parse_t ps_reg, ps_next;
    loop_t loop_reg, loop_next;
    logic hex_reg, hex_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [RC_W-1:0] rc_reg, rc_next;
    logic [7:0] c_reg, c_next;
    logic eoi_reg, eoi_next;
    logic ov_reg, ov_next;
    logic [2:0] k_reg, k_next;
    logic [31:0] v_reg, v_next;
    logic h_reg, h_next;
    logic l_reg, l_next;
    logic [2:0] ek_reg, ek_next;
    logic ev_reg, ev_next;
    logic ecnt_reg, ecnt_next;
    logic [2:0] ekind;
    logic is_digit, is_letter, is_op, is_bin, is_div, op_reports;
    logic [3:0] dval;
    logic out_free, emit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ps_reg <= PS_START;
            loop_reg <= LOOP_NONE;
            hex_reg <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
            rc_reg <= '0;
            ov_reg <= 1'b0;
            ev_reg <= 1'b0;
            ecnt_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ps_reg <= ps_next;
            loop_reg <= loop_next;
            hex_reg <= hex_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            rc_reg <= rc_next;
            ov_reg <= ov_next;
            ev_reg <= ev_next;
            ecnt_reg <= ecnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        eoi_reg <= eoi_next;
        k_reg <= k_next;
        v_reg <= v_next;
        h_reg <= h_next;
        l_reg <= l_next;
        ek_reg <= ek_next;
    end

    always_comb
    begin
        is_digit = (c_reg >= 8'h30 && c_reg <= 8'h39);
        is_letter = (c_reg >= 8'h61 && c_reg <= 8'h66) || (c_reg >= 8'h41 && c_reg <= 8'h46);
        unique case (c_reg) inside
            CH_HEX_OFF, CH_HEX_ON, CH_PEEK, CH_PEEK_ALL, CH_DOT, CH_POP, CH_POP_ALL,
            CH_DUP, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_REM, CH_AND, CH_OR, CH_NOT,
            CH_XOR: is_op = 1'b1;
            default: is_op = 1'b0;
        endcase
        unique case (c_reg) inside
            CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_REM, CH_AND, CH_OR, CH_XOR: is_bin = 1'b1;
            default: is_bin = 1'b0;
        endcase
        // operators that always give a result on a full stack
        unique case (c_reg) inside
            CH_PEEK, CH_PEEK_ALL, CH_DOT, CH_POP, CH_POP_ALL, CH_DUP: op_reports = 1'b1;
            default: op_reports = 1'b0;
        endcase
        is_div = (c_reg == CH_DIV) || (c_reg == CH_REM);
        if (is_digit)
            dval = c_reg[3:0];
        else if (hex_reg)
            dval = c_reg[3:0] + 4'd9;
        else
            dval = 4'd0;
    end

    // output register slot: a pending emission waits in ek/ev until taken
    assign out_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign kind = k_reg;
    assign value = v_reg;
    assign hex_radix = h_reg;
    assign last = l_reg;
    assign op = c_reg;
    assign hex = hex_reg;
    assign digit = dval;

    always_comb
    begin
        state_next = state_reg;
        ps_next = ps_reg;
        loop_next = loop_reg;
        hex_next = hex_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        rc_next = rc_reg;
        c_next = c_reg;
        eoi_next = eoi_reg;
        ov_next = ov_reg && !out_ready;
        k_next = k_reg;
        v_next = v_reg;
        h_next = h_reg;
        l_next = l_reg;
        ek_next = ek_reg;
        ev_next = ev_reg;
        ecnt_next = ecnt_reg;
        ekind = K_UNDER;
        in_ready = 1'b0;
        acc_clear = 1'b0;
        acc_digit = 1'b0;
        mem_we = 1'b0;
        mem_waddr = '0;
        wsel_acc = 1'b0;
        wsel_top = 1'b0;
        wsel_alu = 1'b0;
        mem_re = 1'b0;
        mem_raddr = '0;
        cap_a = 1'b0;
        cap_b = 1'b0;
        alu_go = 1'b0;
        div_start = 1'b0;
        emit_ok = rc_reg < RC_W'(MAX_RESULTS);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    c_next = char_code;
                    eoi_next = end_of_input;
                    rc_next = '0;
                    state_next = (ps_reg == PS_FINAL) ? ST_IDLE : ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (eoi_reg || c_reg == CH_QUIT)
                begin
                    ps_next = PS_FINAL;
                    loop_next = LOOP_POPALL;
                    idx_next = cnt_reg;
                    state_next = ST_LOOP_RD;
                end
                else if (is_digit || is_letter)
                begin
                    if (ps_reg != PS_NUMBER)
                        acc_clear = 1'b1;
                    state_next = ST_PUSH;
                    ps_next = PS_NUMBER;
                end
                else if (ps_reg == PS_NUMBER)
                begin
                    if (cnt_reg >= CNT_W'(STACK_DEPTH))
                    begin
                        ek_next = K_OVER;
                        ev_next = 1'b1;
                        ecnt_next = is_op;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_waddr = cnt_reg[SP_W-1:0];
                        wsel_acc = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        state_next = is_op ? ST_OP : ST_EMIT;
                        ev_next = 1'b0;
                    end
                    ps_next = is_op ? PS_OPERATOR : PS_START;
                end
                else
                begin
                    ps_next = is_op ? PS_OPERATOR : PS_START;
                    ev_next = 1'b0;
                    state_next = is_op ? ST_OP : ST_EMIT;
                end
            end
            ST_PUSH:
            begin
                acc_digit = 1'b1;
                ev_next = 1'b0;
                state_next = ST_EMIT;
            end
            ST_OP:
            begin
                ev_next = 1'b0;
                ecnt_next = 1'b0;
                if (c_reg == CH_HEX_OFF || c_reg == CH_HEX_ON)
                begin
                    hex_next = (c_reg == CH_HEX_ON);
                    state_next = ST_EMIT;
                end
                else if (cnt_reg == '0 || (is_bin && cnt_reg == CNT_W'(1)))
                begin
                    ek_next = K_UNDER;
                    ev_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (c_reg == CH_PEEK_ALL || c_reg == CH_POP_ALL)
                begin
                    loop_next = (c_reg == CH_PEEK_ALL) ? LOOP_PEEK : LOOP_POPALL;
                    idx_next = cnt_reg;
                    state_next = ST_LOOP_RD;
                end
                else if (c_reg == CH_DUP && cnt_reg >= CNT_W'(STACK_DEPTH))
                begin
                    ek_next = K_OVER;
                    ev_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = SP_W'(cnt_reg - CNT_W'(1));
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cap_a = 1'b1;
                if (is_bin)
                begin
                    mem_re = 1'b1;
                    mem_raddr = SP_W'(cnt_reg - CNT_W'(2));
                end
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                if (c_reg == CH_PEEK || c_reg == CH_DOT || c_reg == CH_POP)
                begin
                    ek_next = (c_reg == CH_PEEK) ? K_PEEK : K_POP;
                    ev_next = 1'b1;
                    if (c_reg != CH_PEEK)
                        cnt_next = cnt_reg - CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else if (c_reg == CH_DUP)
                begin
                    mem_we = 1'b1;
                    mem_waddr = cnt_reg[SP_W-1:0];
                    wsel_top = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else if (c_reg == CH_NOT)
                begin
                    alu_go = 1'b1;
                    state_next = ST_WB;
                end
                else
                begin
                    cap_b = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (is_div)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    alu_go = 1'b1;
                    state_next = ST_WB;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                mem_we = 1'b1;
                wsel_alu = 1'b1;
                if (is_bin)
                begin
                    mem_waddr = SP_W'(cnt_reg - CNT_W'(2));
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                    mem_waddr = SP_W'(cnt_reg - CNT_W'(1));
                state_next = ST_EMIT;
            end
            ST_LOOP_RD:
            begin
                if (idx_reg == '0)
                begin
                    ev_next = 1'b0;
                    loop_next = LOOP_NONE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = SP_W'(idx_reg - CNT_W'(1));
                    state_next = ST_LOOP_EMIT;
                end
            end
            ST_LOOP_EMIT:
            begin
                if (!emit_ok || out_free)
                begin
                    if (emit_ok)
                    begin
                        ov_next = 1'b1;
                        k_next = (loop_reg == LOOP_PEEK) ? K_PEEK_ALL : K_POP_ALL;
                        v_next = rdata;
                        h_next = hex_reg;
                        l_next = (idx_reg == CNT_W'(1)) ||
                                 (rc_reg == RC_W'(MAX_RESULTS - 1));
                        rc_next = rc_reg + RC_W'(1);
                    end
                    if (loop_reg == LOOP_POPALL)
                        cnt_next = cnt_reg - CNT_W'(1);
                    idx_next = idx_reg - CNT_W'(1);
                    if (idx_reg == CNT_W'(1))
                    begin
                        loop_next = LOOP_NONE;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_LOOP_RD;
                end
            end
            ST_EMIT:
            begin
                // pending overflow from push may be followed by operator work
                if (!ev_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    ekind = ek_reg;
                    ov_next = 1'b1;
                    k_next = ekind;
                    v_next = (ekind == K_PEEK || ekind == K_POP) ? a_val : 32'd0;
                    h_next = (ekind == K_PEEK || ekind == K_POP) ? hex_reg : 1'b0;
                    l_next = !(ecnt_reg && op_reports);
                    rc_next = rc_reg + RC_W'(1);
                    ev_next = 1'b0;
                    state_next = ecnt_reg ? ST_OP : ST_IDLE;
                    ecnt_next = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    property p_no_out_in_idle_accept;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_DIV) |-> !in_ready;
    endproperty
    a_div_busy: assert property (p_no_out_in_idle_accept) else $error("ready during divide");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH)) else $error("stack count overrun");
    a_final_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ps_reg == PS_FINAL |=> ps_reg == PS_FINAL) else $error("left final");
endmodule
`default_nettype wire

// ----- rtl/rpn_stack_calculator_core.sv -----
// sequencing: a digit passes through decode, push and emit before the sequencer returns to idle
// divide: 32-step shift-subtract; the sequencer waits in its divide state until the divider is done
// stack dumps read and then emit each element in turn, and can stall on output back-pressure
// throughput: one item at a time; next item accepted when the sequencer returns to idle
// reset: rst_n async active low; decimal radix, empty stack, start parse state
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic signed [31:0] value,
    output logic             hex_radix,
    output logic             last
);
    import rpn_pkg::*;

    logic acc_clear, acc_digit, hex, mem_we, wsel_acc, wsel_top, wsel_alu, mem_re;
    logic cap_a, cap_b, alu_go, div_start, div_done;
    logic [3:0] digit;
    logic [SP_W-1:0] mem_waddr, mem_raddr;
    logic [7:0] op;
    logic [31:0] rdata, a_val, value_u;

    rpn_control u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .end_of_input(end_of_input), .out_valid(out_valid),
        .out_ready(out_ready), .kind(kind), .value(value_u), .hex_radix(hex_radix),
        .last(last), .acc_clear(acc_clear), .acc_digit(acc_digit), .digit(digit),
        .hex(hex), .mem_we(mem_we), .mem_waddr(mem_waddr), .wsel_acc(wsel_acc),
        .wsel_top(wsel_top), .wsel_alu(wsel_alu), .mem_re(mem_re),
        .mem_raddr(mem_raddr), .cap_a(cap_a), .cap_b(cap_b), .op(op),
        .alu_go(alu_go), .div_start(div_start), .div_done(div_done),
        .rdata(rdata), .a_val(a_val)
    );

    rpn_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .acc_clear(acc_clear), .acc_digit(acc_digit),
        .digit(digit), .hex(hex), .mem_we(mem_we), .mem_waddr(mem_waddr),
        .wsel_acc(wsel_acc), .wsel_top(wsel_top), .wsel_alu(wsel_alu),
        .mem_re(mem_re), .mem_raddr(mem_raddr), .cap_a(cap_a), .cap_b(cap_b),
        .op(op), .alu_go(alu_go), .div_start(div_start), .div_done(div_done),
        .rdata(rdata), .a_val(a_val)
    );

    assign value = $signed(value_u);
endmodule
`default_nettype wire
